// ----- hdl/cmis_pkg.sv -----
// Shared widths and defaults for the complex magnitude square-root core.
`default_nettype none
package cmis_pkg;

	localparam int SAMPLE_BITS_DEF = 16;      // default sample precision
	localparam int IN_W            = 16;      // real_part / imag_part port width
	localparam int MAG_W           = 16;      // magnitude field width
	localparam int S_TDATA_W       = 2 * IN_W;
	localparam int M_TDATA_W       = MAG_W;

endpackage
`default_nettype wire

// ----- hdl/complex_magnitude_int_sqrt_core.sv -----
// Complex magnitude core: |re + j*im| by rounded integer square root.
//
// Input stream (s_axis): one FFT bin per beat, tdata = {imag_part, real_part},
// tlast marks the final bin of a frame. Output stream (m_axis): one beat per
// input beat in order, tdata = magnitude (unsigned), tlast copied through.
// The magnitude saturates at 2^(SAMPLE_BITS-1) rather than wrapping.
//
// Throughput: one beat per cycle while m_axis is ready. Pipeline stages:
// two for squaring and summing, one per root
// bit for the SAMPLE_BITS-1 bit search stages, and two for rounding.
//
// Every stage carries its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled m_axis fills empty stages first and s_axis
// tready drops only once the whole pipeline is full. Nothing is dropped or
// repeated across a stall. Reset clears all valid bits; data registers are
// not reset.
`default_nettype none
module complex_magnitude_int_sqrt_core #(
	parameter int SAMPLE_BITS = cmis_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [cmis_pkg::S_TDATA_W-1:0]   s_axis_tdata, // {imag_part, real_part}
	input  wire logic                             s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [cmis_pkg::M_TDATA_W-1:0]        m_axis_tdata, // magnitude
	output logic                                  m_axis_tlast
);

	localparam int NW      = 2 * SAMPLE_BITS;
	localparam int RW      = SAMPLE_BITS - 1;
	localparam int LATENCY = SAMPLE_BITS + 3;
	localparam int OCC_W   = $clog2(LATENCY + 2);
	localparam logic [cmis_pkg::MAG_W-1:0] MAG_MAX = cmis_pkg::MAG_W'(1) << (SAMPLE_BITS - 1);

	logic [NW-1:0] num_c  [RW+1];
	logic [NW-1:0] sq_c   [RW+1];
	logic [RW-1:0] est_c  [RW+1];
	logic          last_c [RW+1];
	logic          v_c    [RW+1];
	logic          rdy_c  [RW+1];

	cmis_square #(.SAMPLE_BITS(SAMPLE_BITS)) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.real_part (s_axis_tdata[cmis_pkg::IN_W-1:0]),
		.imag_part (s_axis_tdata[cmis_pkg::S_TDATA_W-1:cmis_pkg::IN_W]),
		.last_in   (s_axis_tlast),
		.out_valid (v_c[0]),
		.out_ready (rdy_c[0]),
		.num       (num_c[0]),
		.last_out  (last_c[0])
	);

	assign sq_c[0]  = '0;
	assign est_c[0] = '0;

	// bit SAMPLE_BITS-2 first, down to bit 0
	for (genvar i = 0; i < RW; i++) begin : g_root
		cmis_root_step #(.SAMPLE_BITS(SAMPLE_BITS), .BIT(RW - 1 - i)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[i]),
			.in_ready  (rdy_c[i]),
			.num_i     (num_c[i]),
			.sq_i      (sq_c[i]),
			.est_i     (est_c[i]),
			.last_i    (last_c[i]),
			.out_valid (v_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.num_o     (num_c[i+1]),
			.sq_o      (sq_c[i+1]),
			.est_o     (est_c[i+1]),
			.last_o    (last_c[i+1])
		);
	end

	cmis_round #(.SAMPLE_BITS(SAMPLE_BITS)) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_c[RW]),
		.in_ready  (rdy_c[RW]),
		.num_i     (num_c[RW]),
		.sq_i      (sq_c[RW]),
		.est_i     (est_c[RW]),
		.last_i    (last_c[RW]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.magnitude (m_axis_tdata),
		.last_o    (m_axis_tlast)
	);

	// beats in flight, for checking only
	logic [OCC_W-1:0] occ_q;
	logic             in_beat, out_beat;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_beat && !out_beat) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (!in_beat && out_beat) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= MAG_MAX)
		else $error("magnitude above saturation value");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while output stage can move");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(LATENCY))
		else $error("more beats in flight than pipeline stages");

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> occ_q != '0)
		else $error("output beat with no input beat pending");

endmodule
`default_nettype wire

// ----- hdl/cmis_square.sv -----
// Sign extension, squaring and sum of squares: two pipeline stages.
`default_nettype none
module cmis_square #(
	parameter int SAMPLE_BITS = cmis_pkg::SAMPLE_BITS_DEF,
	localparam int NW = 2 * SAMPLE_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [cmis_pkg::IN_W-1:0]  real_part,
	input  wire logic [cmis_pkg::IN_W-1:0]  imag_part,
	input  wire logic                       last_in,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [NW-1:0]                   num,
	output logic                            last_out
);

	logic signed [SAMPLE_BITS-1:0] re_s, im_s;
	logic signed [NW-1:0]          re_sq, im_sq;
	logic [NW-1:0] re_sq_s1, im_sq_s1;
	logic          last_s1, valid_s1, ready_s1;
	logic [NW-1:0] num_s2;
	logic          last_s2, valid_s2, ready_s2;

	// only the low SAMPLE_BITS of each part count
	assign re_s  = signed'(real_part[SAMPLE_BITS-1:0]);
	assign im_s  = signed'(imag_part[SAMPLE_BITS-1:0]);
	assign re_sq = re_s * re_s;
	assign im_sq = im_s * im_s;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			re_sq_s1 <= unsigned'(re_sq);
			im_sq_s1 <= unsigned'(im_sq);
			last_s1  <= last_in;
		end
		// each square <= 2^(NW-2), so the sum fits NW bits
		if (ready_s2 && valid_s1) begin
			num_s2  <= re_sq_s1 + im_sq_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign num       = num_s2;
	assign last_out  = last_s2;

endmodule
`default_nettype wire

// ----- hdl/cmis_root_step.sv -----
// One bit of the square-root search, with the running square kept by shift-add.
`default_nettype none
module cmis_root_step #(
	parameter int SAMPLE_BITS = cmis_pkg::SAMPLE_BITS_DEF,
	parameter int BIT         = 0,
	localparam int NW = 2 * SAMPLE_BITS,
	localparam int RW = SAMPLE_BITS - 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [NW-1:0] num_i,
	input  wire logic [NW-1:0] sq_i,
	input  wire logic [RW-1:0] est_i,
	input  wire logic          last_i,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [NW-1:0]      num_o,
	output logic [NW-1:0]      sq_o,
	output logic [RW-1:0]      est_o,
	output logic               last_o
);

	localparam logic [RW-1:0] BIT_MASK = RW'(1) << BIT;
	localparam logic [NW-1:0] BIT_SQ   = NW'(1) << (2 * BIT);

	logic [NW-1:0] sq_cand;
	logic          take;
	logic          valid_q;

	// (est + 2^b)^2 = est^2 + est*2^(b+1) + 2^(2b)
	assign sq_cand  = sq_i + (NW'(est_i) << (BIT + 1)) + BIT_SQ;
	assign take     = sq_cand <= num_i;
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			num_o  <= num_i;
			last_o <= last_i;
			sq_o   <= take ? sq_cand : sq_i;
			est_o  <= take ? (est_i | BIT_MASK) : est_i;
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

// ----- hdl/cmis_round.sv -----
// Round-to-nearest of the truncated root: two pipeline stages, ties keep the root.
`default_nettype none
module cmis_round #(
	parameter int SAMPLE_BITS = cmis_pkg::SAMPLE_BITS_DEF,
	localparam int NW = 2 * SAMPLE_BITS,
	localparam int RW = SAMPLE_BITS - 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [NW-1:0]                num_i,
	input  wire logic [NW-1:0]                sq_i,
	input  wire logic [RW-1:0]                est_i,
	input  wire logic                         last_i,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [cmis_pkg::MAG_W-1:0]        magnitude,
	output logic                              last_o
);

	logic [NW-1:0] num_s1, sq1_s1, below_s1;
	logic [RW-1:0] est_s1;
	logic          last_s1, valid_s1, ready_s1;
	logic [cmis_pkg::MAG_W-1:0] mag_s2;
	logic          last_s2, valid_s2, ready_s2;
	logic [NW-1:0] above;
	logic          up;
	logic [SAMPLE_BITS-1:0] est_up;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// (est+1)^2 below num only when the search saturated: then est+1 is closer
	assign above  = sq1_s1 - num_s1;
	assign up     = (sq1_s1 < num_s1) || (above < below_s1);
	assign est_up = SAMPLE_BITS'(est_s1) + SAMPLE_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			num_s1   <= num_i;
			est_s1   <= est_i;
			last_s1  <= last_i;
			sq1_s1   <= sq_i + (NW'(est_i) << 1) + NW'(1);
			below_s1 <= num_i - sq_i;
		end
		if (ready_s2 && valid_s1) begin
			mag_s2  <= up ? cmis_pkg::MAG_W'(est_up) : cmis_pkg::MAG_W'(est_s1);
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign magnitude = mag_s2;
	assign last_o    = last_s2;

endmodule
`default_nettype wire
